// ===== hdl/spl_pkg.sv =====
`timescale 1ns / 1ps

package spl_pkg;

	// command and reply characters
	localparam logic [7:0] CH_I = 8'h49;
	localparam logic [7:0] CH_A = 8'h41;
	localparam logic [7:0] CH_W = 8'h57;
	localparam logic [7:0] CH_R = 8'h52;
	localparam logic [7:0] CH_Y = 8'h59;
	localparam logic [7:0] CH_N = 8'h4E;

	// result kinds
	localparam logic [2:0] ACT_REPLY = 3'd0;
	localparam logic [2:0] ACT_ERASE = 3'd1;
	localparam logic [2:0] ACT_FILL  = 3'd2;
	localparam logic [2:0] ACT_WRITE = 3'd3;
	localparam logic [2:0] ACT_RESET = 3'd4;

	// configuration register indexes
	localparam logic [1:0] REG_SIG_FIRST  = 2'd0;
	localparam logic [1:0] REG_SIG_SECOND = 2'd1;
	localparam logic [1:0] REG_SIG_THIRD  = 2'd2;

	// command stream position
	typedef enum logic [3:0] {
		PH_CMD,
		PH_ID1,
		PH_ID2,
		PH_ID3,
		PH_ADDR_LO,
		PH_ADDR_HI,
		PH_SUM_LO,
		PH_SUM_HI,
		PH_DATA,
		PH_HALT
	} phase_t;

	// sequencer around the shared adder and the page buffer
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SUM_ADD,
		ST_SUM_FOLD,
		ST_CHECK,
		ST_RD_LO,
		ST_RD_HI,
		ST_FILL,
		ST_WRITE,
		ST_REPLY,
		ST_ADVANCE
	} eng_state_t;

endpackage

// ===== hdl/serial_page_loader_command_engine.sv =====
`timescale 1ns / 1ps

// Ordinary command bytes: each result is registered at its beat and shows in the output register in the next cycle.
// Data bytes: an even position is only stored; an odd position also runs the checksum add and carry fold.
// Final page byte: each fill word is built from two buffer reads and then emitted.
// Async reset clears control, checksum and address state; the page buffer is not cleared.
module serial_page_loader_command_engine #(
	parameter int PAGE_BYTES = 64
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // rx_byte

	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // flash_address[15:0], fill_word[31:16], reply_byte[39:32]
	output logic [2:0]  m_axis_tuser,   // action
	output logic        m_axis_tlast,   // last_of_run

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	localparam int CW = $clog2(PAGE_BYTES + 1);
	localparam int AW = $clog2(PAGE_BYTES);

	spl_pkg::eng_state_t state_q, state_d;
	spl_pkg::phase_t     phase_q, phase_d;

	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] idx_q, idx_d;
	logic [15:0]   load_addr_q, load_addr_d;
	logic [7:0]    low_q, low_d;
	logic [15:0]   exp_sum_q, exp_sum_d;
	logic [15:0]   run_sum_q, run_sum_d;
	logic [15:0]   part_sum_q, part_sum_d;
	logic          carry_q, carry_d;
	logic          id_mis_q, id_mis_d;
	logic          last_q, last_d;
	logic [7:0]    lo_byte_q, lo_byte_d;

	logic [7:0]    sig_first_q, sig_second_q, sig_third_q;

	logic          out_vld_q, out_vld_d;
	logic [2:0]    out_act_q, out_act_d;
	logic [15:0]   out_addr_q, out_addr_d;
	logic [15:0]   out_word_q, out_word_d;
	logic [7:0]    out_reply_q, out_reply_d;
	logic          out_last_q, out_last_d;

	// shared adder
	logic [15:0]   add_a, add_b;
	logic          add_cin;
	logic [16:0]   add_sum;

	// page buffer
	logic [7:0]    mem [PAGE_BYTES];
	logic          mem_we;
	logic [AW-1:0] mem_wa, mem_ra;
	logic [7:0]    mem_wd;
	logic [7:0]    rd_data_q;

	logic          in_beat;
	logic          out_free;
	logic [CW-1:0] count_inc;
	logic [CW-1:0] idx_inc;
	logic [CW:0]   idx_next2;
	logic          hi_ok;

	assign add_sum = {1'b0, add_a} + {1'b0, add_b} + {16'd0, add_cin};

	assign s_axis_tready = (state_q == spl_pkg::ST_IDLE) && !out_vld_q;
	assign in_beat       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_vld_q || m_axis_tready;
	assign cfg_ready     = 1'b1;

	assign count_inc = count_q + CW'(1);
	assign idx_inc   = idx_q + CW'(1);
	assign idx_next2 = {1'b0, idx_q} + (CW+1)'(2);
	assign hi_ok     = idx_inc < CW'(PAGE_BYTES);

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {out_reply_q, out_word_q, out_addr_q};
	assign m_axis_tuser  = out_act_q;
	assign m_axis_tlast  = out_last_q;

	always_comb begin
		state_d     = state_q;
		phase_d     = phase_q;
		count_d     = count_q;
		idx_d       = idx_q;
		load_addr_d = load_addr_q;
		low_d       = low_q;
		exp_sum_d   = exp_sum_q;
		run_sum_d   = run_sum_q;
		part_sum_d  = part_sum_q;
		carry_d     = carry_q;
		id_mis_d    = id_mis_q;
		last_d      = last_q;
		lo_byte_d   = lo_byte_q;

		out_vld_d   = out_vld_q && !m_axis_tready;
		out_act_d   = out_act_q;
		out_addr_d  = out_addr_q;
		out_word_d  = out_word_q;
		out_reply_d = out_reply_q;
		out_last_d  = out_last_q;

		add_a   = load_addr_q;
		add_b   = 16'(idx_q);
		add_cin = 1'b0;

		mem_we = 1'b0;
		mem_wa = count_q[AW-1:0];
		mem_wd = s_axis_tdata;
		mem_ra = idx_q[AW-1:0];

		case (state_q)
			spl_pkg::ST_IDLE: begin
				if (in_beat) begin
					// default result: a closing reply, overridden below
					out_act_d   = spl_pkg::ACT_REPLY;
					out_addr_d  = 16'd0;
					out_word_d  = 16'd0;
					out_reply_d = spl_pkg::CH_N;
					out_last_d  = 1'b1;
					case (phase_q)
						spl_pkg::PH_CMD: begin
							case (s_axis_tdata)
								spl_pkg::CH_I: begin
									id_mis_d = 1'b0;
									phase_d  = spl_pkg::PH_ID1;
								end
								spl_pkg::CH_A: begin
									phase_d = spl_pkg::PH_ADDR_LO;
								end
								spl_pkg::CH_W: begin
									out_vld_d  = 1'b1;
									out_act_d  = spl_pkg::ACT_ERASE;
									out_addr_d = load_addr_q;
									out_reply_d = 8'd0;
									phase_d    = spl_pkg::PH_SUM_LO;
								end
								spl_pkg::CH_R: begin
									out_vld_d   = 1'b1;
									out_act_d   = spl_pkg::ACT_RESET;
									out_reply_d = 8'd0;
									phase_d     = spl_pkg::PH_HALT;
								end
								default: begin
									out_vld_d = 1'b1;
								end
							endcase
						end
						spl_pkg::PH_ID1: begin
							if (s_axis_tdata != sig_first_q) id_mis_d = 1'b1;
							phase_d = spl_pkg::PH_ID2;
						end
						spl_pkg::PH_ID2: begin
							if (s_axis_tdata != sig_second_q) id_mis_d = 1'b1;
							phase_d = spl_pkg::PH_ID3;
						end
						spl_pkg::PH_ID3: begin
							out_vld_d = 1'b1;
							if (!id_mis_q && s_axis_tdata == sig_third_q)
								out_reply_d = spl_pkg::CH_Y;
							id_mis_d = id_mis_q || (s_axis_tdata != sig_third_q);
							phase_d  = spl_pkg::PH_CMD;
						end
						spl_pkg::PH_ADDR_LO: begin
							low_d   = s_axis_tdata;
							phase_d = spl_pkg::PH_ADDR_HI;
						end
						spl_pkg::PH_ADDR_HI: begin
							load_addr_d = {s_axis_tdata, low_q};
							out_vld_d   = 1'b1;
							out_reply_d = spl_pkg::CH_Y;
							phase_d     = spl_pkg::PH_CMD;
						end
						spl_pkg::PH_SUM_LO: begin
							low_d   = s_axis_tdata;
							phase_d = spl_pkg::PH_SUM_HI;
						end
						spl_pkg::PH_SUM_HI: begin
							exp_sum_d = {s_axis_tdata, low_q};
							run_sum_d = 16'd0;
							count_d   = '0;
							phase_d   = spl_pkg::PH_DATA;
						end
						spl_pkg::PH_DATA: begin
							mem_we  = 1'b1;
							count_d = count_inc;
							last_d  = count_inc == CW'(PAGE_BYTES);
							if (count_q[0]) begin
								// odd position: pair completes, add it in
								state_d = spl_pkg::ST_SUM_ADD;
							end else begin
								low_d = s_axis_tdata;
								if (count_inc == CW'(PAGE_BYTES))
									state_d = spl_pkg::ST_CHECK;
							end
							if (count_inc == CW'(PAGE_BYTES)) begin
								count_d = '0;
								phase_d = spl_pkg::PH_CMD;
							end
						end
						default: begin
							phase_d = spl_pkg::PH_HALT;
						end
					endcase
				end
			end

			spl_pkg::ST_SUM_ADD: begin
				// low_q holds the even byte; lo_byte_q caught the odd byte at its beat
				add_a      = run_sum_q;
				add_b      = {lo_byte_q, low_q};
				part_sum_d = add_sum[15:0];
				carry_d    = add_sum[16];
				state_d    = spl_pkg::ST_SUM_FOLD;
			end

			spl_pkg::ST_SUM_FOLD: begin
				// end-around carry
				add_a     = part_sum_q;
				add_b     = 16'd0;
				add_cin   = carry_q;
				run_sum_d = add_sum[15:0];
				state_d   = last_q ? spl_pkg::ST_CHECK : spl_pkg::ST_IDLE;
			end

			spl_pkg::ST_CHECK: begin
				idx_d = '0;
				if (run_sum_q != exp_sum_q) begin
					if (out_free) begin
						out_vld_d   = 1'b1;
						out_act_d   = spl_pkg::ACT_REPLY;
						out_addr_d  = 16'd0;
						out_word_d  = 16'd0;
						out_reply_d = spl_pkg::CH_N;
						out_last_d  = 1'b1;
						state_d     = spl_pkg::ST_IDLE;
					end
				end else begin
					state_d = spl_pkg::ST_RD_LO;
				end
			end

			spl_pkg::ST_RD_LO: begin
				mem_ra  = idx_q[AW-1:0];
				state_d = spl_pkg::ST_RD_HI;
			end

			spl_pkg::ST_RD_HI: begin
				lo_byte_d = rd_data_q;
				mem_ra    = hi_ok ? idx_inc[AW-1:0] : idx_q[AW-1:0];
				state_d   = spl_pkg::ST_FILL;
			end

			spl_pkg::ST_FILL: begin
				add_a = load_addr_q;
				add_b = 16'(idx_q);
				// keep the high byte on the read port while the sink stalls
				mem_ra = hi_ok ? idx_inc[AW-1:0] : idx_q[AW-1:0];
				if (out_free) begin
					out_vld_d   = 1'b1;
					out_act_d   = spl_pkg::ACT_FILL;
					out_addr_d  = add_sum[15:0];
					out_word_d  = {hi_ok ? rd_data_q : 8'd0, lo_byte_q};
					out_reply_d = 8'd0;
					out_last_d  = 1'b0;
					idx_d       = idx_next2[CW-1:0];
					if (idx_next2 >= (CW+1)'(PAGE_BYTES))
						state_d = spl_pkg::ST_WRITE;
					else
						state_d = spl_pkg::ST_RD_LO;
				end
			end

			spl_pkg::ST_WRITE: begin
				if (out_free) begin
					out_vld_d   = 1'b1;
					out_act_d   = spl_pkg::ACT_WRITE;
					out_addr_d  = load_addr_q;
					out_word_d  = 16'd0;
					out_reply_d = 8'd0;
					out_last_d  = 1'b0;
					state_d     = spl_pkg::ST_REPLY;
				end
			end

			spl_pkg::ST_REPLY: begin
				if (out_free) begin
					out_vld_d   = 1'b1;
					out_act_d   = spl_pkg::ACT_REPLY;
					out_addr_d  = 16'd0;
					out_word_d  = 16'd0;
					out_reply_d = spl_pkg::CH_Y;
					out_last_d  = 1'b1;
					state_d     = spl_pkg::ST_ADVANCE;
				end
			end

			spl_pkg::ST_ADVANCE: begin
				add_a       = load_addr_q;
				add_b       = 16'(PAGE_BYTES);
				load_addr_d = add_sum[15:0];
				state_d     = spl_pkg::ST_IDLE;
			end

			default: begin
				state_d = spl_pkg::ST_IDLE;
			end
		endcase
	end

	// control state with async reset; the odd data byte is kept for the pair add
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= spl_pkg::ST_IDLE;
			phase_q     <= spl_pkg::PH_CMD;
			count_q     <= '0;
			idx_q       <= '0;
			load_addr_q <= 16'd0;
			low_q       <= 8'd0;
			exp_sum_q   <= 16'd0;
			run_sum_q   <= 16'd0;
			part_sum_q  <= 16'd0;
			carry_q     <= 1'b0;
			id_mis_q    <= 1'b0;
			last_q      <= 1'b0;
			lo_byte_q   <= 8'd0;
			out_vld_q   <= 1'b0;
		end else begin
			state_q     <= state_d;
			phase_q     <= phase_d;
			count_q     <= count_d;
			idx_q       <= idx_d;
			load_addr_q <= load_addr_d;
			low_q       <= low_d;
			exp_sum_q   <= exp_sum_d;
			run_sum_q   <= run_sum_d;
			part_sum_q  <= part_sum_d;
			carry_q     <= carry_d;
			id_mis_q    <= id_mis_d;
			last_q      <= last_d;
			lo_byte_q   <= (in_beat && phase_q == spl_pkg::PH_DATA) ? s_axis_tdata : lo_byte_d;
			out_vld_q   <= out_vld_d;
		end
	end

	always_ff @(posedge clk) begin
		out_act_q   <= out_act_d;
		out_addr_q  <= out_addr_d;
		out_word_q  <= out_word_d;
		out_reply_q <= out_reply_d;
		out_last_q  <= out_last_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sig_first_q  <= 8'd30;
			sig_second_q <= 8'd149;
			sig_third_q  <= 8'd15;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				spl_pkg::REG_SIG_FIRST:  sig_first_q  <= cfg_data;
				spl_pkg::REG_SIG_SECOND: sig_second_q <= cfg_data;
				spl_pkg::REG_SIG_THIRD:  sig_third_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		rd_data_q <= mem[mem_ra];
	end

endmodule
